/* rtl/led_pkg.sv */
package led_pkg;

    localparam int LINE_LEN_DEF   = 63;
    localparam int HIST_DEPTH_DEF = 16;
    localparam int MAX_CHARS      = 63;

    localparam logic [7:0] K_EOT   = 8'd4;
    localparam logic [7:0] K_LF    = 8'd10;
    localparam logic [7:0] K_DEL   = 8'd127;
    localparam logic [7:0] K_ESC   = 8'd27;
    localparam logic [7:0] K_LBR   = 8'h5B;
    localparam logic [7:0] K_LEFT  = 8'h44;
    localparam logic [7:0] K_RIGHT = 8'h43;
    localparam logic [7:0] K_HOME  = 8'h48;
    localparam logic [7:0] K_END   = 8'h46;
    localparam logic [7:0] K_UP    = 8'h41;
    localparam logic [7:0] K_DOWN  = 8'h42;
    localparam logic [7:0] K_THREE = 8'h33;

    typedef enum logic [3:0] {
        OP_REPORT, OP_EOI, OP_LEFT, OP_RIGHT, OP_HOME, OP_END, OP_UP, OP_DOWN,
        OP_DEL_AT, OP_BKSP, OP_ENTER, OP_INSERT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    function automatic logic printable(input logic [7:0] b);
        return (b >= 8'd32) && (b <= 8'd126);
    endfunction

endpackage

/* rtl/led_front.sv */
module led_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            q_full,
    output led_pkg::push_t  push
);
    import led_pkg::*;

    typedef enum logic [3:0] {
        ESC_NONE = 4'b0001,
        ESC_SEEN = 4'b0010,
        ESC_BRKT = 4'b0100,
        ESC_DEL  = 4'b1000
    } esc_t;

    esc_t esc_reg, esc_next;
    logic take;
    logic report;
    cmd_t cmd;

    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;

    always_comb
    begin
        esc_next = esc_reg;
        report   = 1'b1;
        cmd.op   = OP_REPORT;
        cmd.code = s_tdata;
        unique case (esc_reg)
            ESC_SEEN:
            begin
                if (s_tdata == K_LBR)
                begin
                    esc_next = ESC_BRKT;
                    report   = 1'b0;
                end
                else
                begin
                    esc_next = ESC_NONE;
                    cmd.code = K_ESC;
                end
            end
            ESC_BRKT:
            begin
                esc_next = ESC_NONE;
                unique case (s_tdata)
                    K_LEFT:  cmd.op = OP_LEFT;
                    K_RIGHT: cmd.op = OP_RIGHT;
                    K_HOME:  cmd.op = OP_HOME;
                    K_END:   cmd.op = OP_END;
                    K_UP:    cmd.op = OP_UP;
                    K_DOWN:  cmd.op = OP_DOWN;
                    K_THREE:
                    begin
                        esc_next = ESC_DEL;
                        report   = 1'b0;
                    end
                    default: cmd.code = K_ESC;
                endcase
            end
            ESC_DEL:
            begin
                esc_next = ESC_NONE;
                if (printable(s_tdata))
                begin
                    cmd.op   = OP_DEL_AT;
                    cmd.code = K_THREE;
                end
                else
                begin
                    cmd.code = K_ESC;
                end
            end
            default:
            begin
                esc_next = ESC_NONE;
                unique case (s_tdata)
                    K_EOT: cmd.op = OP_EOI;
                    K_LF:  cmd.op = OP_ENTER;
                    K_DEL: cmd.op = OP_BKSP;
                    K_ESC:
                    begin
                        esc_next = ESC_SEEN;
                        report   = 1'b0;
                    end
                    default:
                    begin
                        if (printable(s_tdata))
                        begin
                            cmd.op = OP_INSERT;
                        end
                    end
                endcase
            end
        endcase
    end

    assign push.valid = take && report;
    assign push.cmd   = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= ESC_NONE;
        end
        else if (take)
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

/* rtl/led_queue.sv */
module led_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  led_pkg::push_t push,
    output logic           full,
    output logic           avail,
    output led_pkg::cmd_t  head,
    input  logic           pop
);
    import led_pkg::*;

    cmd_t       ent_reg [2];
    logic       rdp_reg;
    logic       wrp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = ent_reg[rdp_reg];

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            ent_reg[wrp_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdp_reg <= 1'b0;
            wrp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push.valid)
            begin
                wrp_reg <= !wrp_reg;
            end
            if (pop)
            begin
                rdp_reg <= !rdp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push.valid} - {1'b0, pop};
        end
    end

endmodule

/* rtl/led_back.sv */
module led_back #(
    parameter int LINE_LEN   = led_pkg::LINE_LEN_DEF,
    parameter int HIST_DEPTH = led_pkg::HIST_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          avail,
    input  led_pkg::cmd_t head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);
    import led_pkg::*;

    localparam int CW   = $clog2(LINE_LEN + 1);
    localparam int PW   = $clog2(LINE_LEN);
    localparam int EW   = $clog2(HIST_DEPTH);
    localparam int NW   = $clog2(HIST_DEPTH + 1);
    localparam int AW   = EW + PW;
    localparam int MEMD = HIST_DEPTH << PW;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LEN  = 7'b0000010,
        S_MOVE = 7'b0000100,
        S_OPEN = 7'b0001000,
        S_CPRD = 7'b0010000,
        S_CPEM = 7'b0100000,
        S_STAT = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       pad;
        logic [4:0] hcount;
        logic [3:0] hpos;
        logic [5:0] len;
        logic [5:0] cur;
        logic       full;
        logic       eoi;
        logic [7:0] code;
        logic [7:0] ch;
    } out_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] len_reg, len_next;
    logic [EW-1:0] ce_reg, ce_next;
    logic [NW-1:0] count_reg, count_next;
    logic [EW-1:0] oldest_reg, oldest_next;
    logic [7:0]    code_reg, code_next;
    logic          eoi_reg, eoi_next;
    logic          full_reg, full_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          up_reg, up_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_ptr_reg, pend_ptr_next;
    logic          put_reg, put_next;
    logic [CW-1:0] put_ptr_reg, put_ptr_next;
    logic [7:0]    put_ch_reg, put_ch_next;
    logic [EW-1:0] src_reg, src_next;
    logic [EW-1:0] dst_reg, dst_next;
    logic [EW-1:0] open_reg, open_next;
    logic [CW-1:0] k_reg, k_next;
    logic          ov_reg, ov_next;
    logic          okind_reg, okind_next;
    logic          olast_reg, olast_next;
    out_t          out_reg, out_next;

    logic [7:0]    line_mem [MEMD];
    logic [CW-1:0] len_mem [HIST_DEPTH];
    logic          lw_en, lr_en, hw_en, hr_en;
    logic [AW-1:0] lw_addr, lr_addr;
    logic [7:0]    lw_data, lr_data_reg;
    logic [EW-1:0] hw_addr, hr_addr;
    logic [CW-1:0] hw_data, hr_data_reg;

    logic [EW-1:0] cur_slot;
    logic [EW-1:0] newest;
    logic [CW-1:0] wptr;
    logic          out_free;
    logic          emit;

    function automatic logic [EW-1:0] slot_of(input logic [EW-1:0] base,
                                              input logic [EW-1:0] idx);
        logic [EW:0] s;
        s = {1'b0, base} + {1'b0, idx};
        if (s >= (EW+1)'(HIST_DEPTH))
        begin
            s = s - (EW+1)'(HIST_DEPTH);
        end
        return s[EW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            line_mem[lw_addr] <= lw_data;
        end
        if (lr_en)
        begin
            lr_data_reg <= line_mem[lr_addr];
        end
        if (hw_en)
        begin
            len_mem[hw_addr] <= hw_data;
        end
        if (hr_en)
        begin
            hr_data_reg <= len_mem[hr_addr];
        end
    end

    assign cur_slot = slot_of(oldest_reg, ce_reg);
    assign newest   = slot_of(oldest_reg, EW'(count_reg - 1'b1));
    assign wptr     = up_reg ? pend_ptr_reg + 1'b1 : pend_ptr_reg - 1'b1;
    assign out_free = !ov_reg || m_tready;
    assign emit     = int'(k_reg) < MAX_CHARS;

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        len_next      = len_reg;
        ce_next       = ce_reg;
        count_next    = count_reg;
        oldest_next   = oldest_reg;
        code_next     = code_reg;
        eoi_next      = eoi_reg;
        full_next     = full_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        up_next       = up_reg;
        pend_next     = pend_reg;
        pend_ptr_next = pend_ptr_reg;
        put_next      = put_reg;
        put_ptr_next  = put_ptr_reg;
        put_ch_next   = put_ch_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        open_next     = open_reg;
        k_next        = k_reg;
        ov_next       = ov_reg && !m_tready;
        okind_next    = okind_reg;
        olast_next    = olast_reg;
        out_next      = out_reg;
        pop           = 1'b0;
        lw_en         = 1'b0;
        lw_addr       = '0;
        lw_data       = '0;
        lr_en         = 1'b0;
        lr_addr       = '0;
        hw_en         = 1'b0;
        hw_addr       = '0;
        hw_data       = '0;
        hr_en         = 1'b0;
        hr_addr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop        = 1'b1;
                    code_next  = head.code;
                    eoi_next   = (head.op == OP_EOI);
                    full_next  = 1'b0;
                    state_next = S_STAT;
                    unique case (head.op)
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cursor_reg < len_reg)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        OP_HOME: cursor_next = '0;
                        OP_END:  cursor_next = len_reg;
                        OP_UP:
                        begin
                            if (ce_reg != '0)
                            begin
                                ce_next    = ce_reg - 1'b1;
                                hr_en      = 1'b1;
                                hr_addr    = slot_of(oldest_reg, ce_reg - 1'b1);
                                state_next = S_LEN;
                            end
                            else
                            begin
                                code_next = K_ESC;
                            end
                        end
                        OP_DOWN:
                        begin
                            if (NW'(ce_reg) + 1'b1 < count_reg)
                            begin
                                ce_next    = ce_reg + 1'b1;
                                hr_en      = 1'b1;
                                hr_addr    = slot_of(oldest_reg, ce_reg + 1'b1);
                                state_next = S_LEN;
                            end
                            else
                            begin
                                code_next = K_ESC;
                            end
                        end
                        OP_DEL_AT:
                        begin
                            if (cursor_reg < len_reg)
                            begin
                                len_next   = len_reg - 1'b1;
                                hw_en      = 1'b1;
                                hw_addr    = cur_slot;
                                hw_data    = len_reg - 1'b1;
                                ptr_next   = cursor_reg + 1'b1;
                                cnt_next   = len_reg - cursor_reg - 1'b1;
                                up_next    = 1'b0;
                                put_next   = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        OP_BKSP:
                        begin
                            if (cursor_reg != '0)
                            begin
                                len_next    = len_reg - 1'b1;
                                cursor_next = cursor_reg - 1'b1;
                                hw_en       = 1'b1;
                                hw_addr     = cur_slot;
                                hw_data     = len_reg - 1'b1;
                                ptr_next    = cursor_reg;
                                cnt_next    = len_reg - cursor_reg;
                                up_next     = 1'b0;
                                put_next    = 1'b0;
                                state_next  = S_MOVE;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (len_reg < CW'(LINE_LEN))
                            begin
                                len_next     = len_reg + 1'b1;
                                cursor_next  = cursor_reg + 1'b1;
                                hw_en        = 1'b1;
                                hw_addr      = cur_slot;
                                hw_data      = len_reg + 1'b1;
                                ptr_next     = len_reg - 1'b1;
                                cnt_next     = len_reg - cursor_reg;
                                up_next      = 1'b1;
                                put_next     = 1'b1;
                                put_ptr_next = cursor_reg;
                                put_ch_next  = head.code;
                                state_next   = S_MOVE;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        OP_ENTER:
                        begin
                            hw_en    = 1'b1;
                            hw_addr  = newest;
                            hw_data  = len_reg;
                            src_next = cur_slot;
                            dst_next = newest;
                            k_next   = '0;
                            cnt_next = len_reg;
                            if (count_reg < NW'(HIST_DEPTH))
                            begin
                                count_next = count_reg + 1'b1;
                                ce_next    = EW'(count_reg);
                                open_next  = slot_of(oldest_reg, EW'(count_reg));
                            end
                            else
                            begin
                                oldest_next = slot_of(oldest_reg, EW'(1));
                                ce_next     = EW'(HIST_DEPTH - 1);
                                open_next   = oldest_reg;
                            end
                            cursor_next = '0;
                            len_next    = '0;
                            state_next  = S_OPEN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                cursor_next = hr_data_reg;
                len_next    = hr_data_reg;
                state_next  = S_STAT;
            end
            S_MOVE:
            begin
                if (pend_reg)
                begin
                    lw_en   = 1'b1;
                    lw_addr = {cur_slot, wptr[PW-1:0]};
                    lw_data = lr_data_reg;
                end
                if (cnt_reg != '0)
                begin
                    lr_en         = 1'b1;
                    lr_addr       = {cur_slot, ptr_reg[PW-1:0]};
                    pend_next     = 1'b1;
                    pend_ptr_next = ptr_reg;
                    ptr_next      = up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (put_reg)
                        begin
                            lw_en   = 1'b1;
                            lw_addr = {cur_slot, put_ptr_reg[PW-1:0]};
                            lw_data = put_ch_reg;
                        end
                        state_next = S_STAT;
                    end
                end
            end
            S_OPEN:
            begin
                hw_en      = 1'b1;
                hw_addr    = open_reg;
                hw_data    = '0;
                state_next = (cnt_reg != '0) ? S_CPRD : S_STAT;
            end
            S_CPRD:
            begin
                lr_en      = 1'b1;
                lr_addr    = {src_reg, k_reg[PW-1:0]};
                state_next = S_CPEM;
            end
            S_CPEM:
            begin
                lw_en   = 1'b1;
                lw_addr = {dst_reg, k_reg[PW-1:0]};
                lw_data = lr_data_reg;
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        ov_next         = 1'b1;
                        okind_next      = 1'b1;
                        olast_next      = 1'b0;
                        out_next.pad    = 1'b0;
                        out_next.hcount = 5'(count_reg);
                        out_next.hpos   = 4'(ce_reg);
                        out_next.len    = 6'(len_reg);
                        out_next.cur    = 6'(cursor_reg);
                        out_next.full   = 1'b0;
                        out_next.eoi    = 1'b0;
                        out_next.code   = K_LF;
                        out_next.ch     = lr_data_reg;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == cnt_reg) ? S_STAT : S_CPRD;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    ov_next         = 1'b1;
                    okind_next      = 1'b0;
                    olast_next      = 1'b1;
                    out_next.pad    = 1'b0;
                    out_next.hcount = 5'(count_reg);
                    out_next.hpos   = 4'(ce_reg);
                    out_next.len    = 6'(len_reg);
                    out_next.cur    = 6'(cursor_reg);
                    out_next.full   = full_reg;
                    out_next.eoi    = eoi_reg;
                    out_next.code   = code_reg;
                    out_next.ch     = 8'd0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        eoi_reg      <= eoi_next;
        full_reg     <= full_next;
        ptr_reg      <= ptr_next;
        cnt_reg      <= cnt_next;
        up_reg       <= up_next;
        pend_ptr_reg <= pend_ptr_next;
        put_reg      <= put_next;
        put_ptr_reg  <= put_ptr_next;
        put_ch_reg   <= put_ch_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        open_reg     <= open_next;
        k_reg        <= k_next;
        okind_reg    <= okind_next;
        olast_reg    <= olast_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            len_reg    <= '0;
            ce_reg     <= '0;
            count_reg  <= NW'(1);
            oldest_reg <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            ce_reg     <= ce_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

/* rtl/line_editor_with_history.sv */
// Insert and delete shift the characters behind the cursor, one read and one write
// of the line store a cycle.
// Enter copies and emits the stored characters one at a time, waiting while the output stalls.
// Reset (rst_n low, asynchronous) empties the queue and output, one empty entry open.
module line_editor_with_history #(
    parameter int LINE_LEN   = led_pkg::LINE_LEN_DEF,
    parameter int HIST_DEPTH = led_pkg::HIST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_char, key_code, end_of_input, line_full, cursor_pos, line_length,
    // history_pos, history_count, zero pad
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // last_item
);
    import led_pkg::*;

    push_t push;
    cmd_t  head;
    logic  q_full;
    logic  avail;
    logic  pop;

    led_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    led_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .avail (avail),
        .head  (head),
        .pop   (pop)
    );

    led_back #(
        .LINE_LEN   (LINE_LEN),
        .HIST_DEPTH (HIST_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("line character transfer marked last");

    a_char_fresh_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[15:8] == K_LF && m_tdata[29:18] == 12'd0)
        else $error("line character without an opened empty entry");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && LINE_LEN < 64 |-> m_tdata[23:18] <= m_tdata[29:24])
        else $error("cursor beyond line end");

    a_hist_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && HIST_DEPTH <= 16 |-> {1'b0, m_tdata[33:30]} < m_tdata[38:34])
        else $error("history position outside kept entries");

endmodule

/* bench/line_editor_with_history_chk.sv */
module line_editor_with_history_chk
    import led_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LLEN  = LINE_LEN_DEF;
    localparam int DEPTH = HIST_DEPTH_DEF;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [39:0] word;
    } edit_result_t;

    edit_result_t results_due[$];

    logic [7:0] chars [0:DEPTH*LLEN-1];
    int         slot_len [0:DEPTH-1];
    int         cur_pos;
    int         sel_entry;
    int         n_entries;
    int         first_slot;
    int         esc_state;

    function automatic int slot_at(input int i);
        return (first_slot + i) % DEPTH;
    endfunction

    function automatic logic [39:0] status_word(input logic [7:0] ch, input logic [7:0] code,
                                                input logic eoi, input logic full);
        logic [39:0] w;
        w = '0;
        w[7:0]   = ch;
        w[15:8]  = code;
        w[16]    = eoi;
        w[17]    = full;
        w[23:18] = cur_pos[5:0];
        w[29:24] = slot_len[slot_at(sel_entry)][5:0];
        w[33:30] = sel_entry[3:0];
        w[38:34] = n_entries[4:0];
        return w;
    endfunction

    function automatic void edit_line(input logic [7:0] b);
        logic [7:0]   code;
        logic         eoi;
        logic         full;
        logic         report;
        logic [7:0]   line_out [0:MAX_CHARS-1];
        int           nout;
        int           cs;
        int           base;
        int           len;
        int           newest;
        edit_result_t r;
        code = b;
        eoi = 1'b0;
        full = 1'b0;
        report = 1'b1;
        nout = 0;
        cs = slot_at(sel_entry);
        base = cs * LLEN;
        len = slot_len[cs];
        if (esc_state == 1) begin
            if (b == K_LBR) begin
                esc_state = 2;
                report = 1'b0;
            end
            else begin
                esc_state = 0;
                code = K_ESC;
            end
        end
        else if (esc_state == 2) begin
            esc_state = 0;
            if (b == K_LEFT) begin
                if (cur_pos > 0 && cur_pos <= len) cur_pos--;
            end
            else if (b == K_RIGHT) begin
                if (cur_pos < len) cur_pos++;
            end
            else if (b == K_HOME) cur_pos = 0;
            else if (b == K_END) cur_pos = len;
            else if (b == K_UP) begin
                if (sel_entry > 0) begin
                    sel_entry--;
                    cur_pos = slot_len[slot_at(sel_entry)];
                end
                else code = K_ESC;
            end
            else if (b == K_DOWN) begin
                if (sel_entry + 1 < n_entries) begin
                    sel_entry++;
                    cur_pos = slot_len[slot_at(sel_entry)];
                end
                else code = K_ESC;
            end
            else if (b == K_THREE) begin
                esc_state = 3;
                report = 1'b0;
            end
            else code = K_ESC;
        end
        else if (esc_state == 3) begin
            esc_state = 0;
            if (b >= 8'd32 && b <= 8'd126) begin
                code = K_THREE;
                if (cur_pos < len) begin
                    for (int i = cur_pos; i < len - 1; i++) chars[base+i] = chars[base+i+1];
                    slot_len[cs] = len - 1;
                end
            end
            else code = K_ESC;
        end
        else if (b == K_EOT) eoi = 1'b1;
        else if (b == K_LF) begin
            newest = slot_at(n_entries - 1);
            if (sel_entry + 1 < n_entries) begin
                for (int i = 0; i < len; i++) chars[newest*LLEN+i] = chars[base+i];
                slot_len[newest] = len;
            end
            nout = slot_len[newest] > MAX_CHARS ? MAX_CHARS : slot_len[newest];
            for (int i = 0; i < nout; i++) line_out[i] = chars[newest*LLEN+i];
            if (n_entries < DEPTH) n_entries++;
            else first_slot = (first_slot + 1) % DEPTH;
            sel_entry = n_entries - 1;
            slot_len[slot_at(sel_entry)] = 0;
            cur_pos = 0;
        end
        else if (b == K_DEL) begin
            if (cur_pos > 0) begin
                for (int i = cur_pos - 1; i < len - 1; i++) chars[base+i] = chars[base+i+1];
                slot_len[cs] = len - 1;
                cur_pos--;
            end
        end
        else if (b == K_ESC) begin
            esc_state = 1;
            report = 1'b0;
        end
        else if (b >= 8'd32 && b <= 8'd126) begin
            if (len < LLEN) begin
                for (int i = len; i > cur_pos; i--) chars[base+i] = chars[base+i-1];
                chars[base+cur_pos] = b;
                slot_len[cs] = len + 1;
                cur_pos++;
            end
            else full = 1'b1;
        end
        if (report) begin
            for (int i = 0; i < nout; i++) begin
                r.kind = 1'b1;
                r.last = 1'b0;
                r.word = status_word(line_out[i], K_LF, eoi, full);
                results_due.push_back(r);
            end
            r.kind = 1'b0;
            r.last = 1'b1;
            r.word = status_word(8'd0, code, eoi, full);
            results_due.push_back(r);
        end
    endfunction

    assign pending = results_due.size();

    initial
    begin
        errors = 0;
        for (int i = 0; i < DEPTH*LLEN; i++) chars[i] = '0;
        for (int i = 0; i < DEPTH; i++) slot_len[i] = 0;
        cur_pos = 0;
        sel_entry = 0;
        n_entries = 1;
        first_slot = 0;
        esc_state = 0;
    end

    always @(posedge clk)
    begin
        edit_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected transfer tuser=%b tlast=%b tdata=%h",
                             $time, m_tuser, m_tlast, m_tdata);
                    errors++;
                end
                else begin
                    want = results_due.pop_front();
                    if (want.kind !== m_tuser || want.last !== m_tlast
                        || want.word !== m_tdata) begin
                        $display("%0t: mismatch expected tuser=%b tlast=%b tdata=%h",
                                 $time, want.kind, want.last, want.word);
                        $display("%0t:            actual tuser=%b tlast=%b tdata=%h",
                                 $time, m_tuser, m_tlast, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) edit_line(s_tdata);
        end
    end

endmodule

/* bench/line_editor_with_history_tb.sv */
module line_editor_with_history_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import led_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          keys_sent;
    int          hold_left;

    line_editor_with_history dut (.*);

    line_editor_with_history_chk chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stalls, with quiet stretches of no stalling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ((keys_sent / 60) % 3 != 1 && $urandom_range(0, 3) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= gap_len();
        end
        else m_tready <= 1'b1;
    end

    task automatic send_key(input logic [7:0] b);
        int g;
        g = ((keys_sent / 60) % 3 == 2) ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        keys_sent++;
    endtask

    task automatic send_seq(input logic [7:0] b);
        send_key(K_ESC);
        send_key(K_LBR);
        send_key(b);
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(32, 126));
    endfunction

    initial
    begin
        logic [7:0] moves [6];
        int         p;
        int         waited;
        moves = '{K_LEFT, K_RIGHT, K_HOME, K_END, K_UP, K_DOWN};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        keys_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_key(K_DEL);
        send_key(8'd32);
        send_key(8'd126);
        send_key(8'd65);
        send_seq(K_LEFT);
        send_seq(K_HOME);
        send_seq(K_RIGHT);
        send_seq(K_END);
        send_key(K_ESC);
        send_key(K_THREE);
        send_seq(K_THREE);
        send_key(8'd120);
        send_seq(K_HOME);
        send_seq(K_THREE);
        send_key(8'd1);
        send_seq(8'h5A);
        send_seq(K_UP);
        send_seq(K_DOWN);
        send_key(K_EOT);
        send_key(8'h80);
        send_key(8'hFF);
        send_key(8'h00);
        send_key(K_LF);
        send_seq(K_UP);
        send_seq(K_UP);
        send_key(K_LF);

        while (keys_sent < 420) begin
            p = $urandom_range(0, 99);
            if (p < 42) send_key(any_printable());
            else if (p < 52) send_key(K_DEL);
            else if (p < 70) send_seq(moves[$urandom_range(0, 5)]);
            else if (p < 76) begin
                send_seq(K_THREE);
                send_key($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 31)) : any_printable());
            end
            else if (p < 87) send_key(K_LF);
            else if (p < 90) repeat (66) send_key(any_printable());
            else if (p < 94) begin
                send_key(K_ESC);
                send_key(8'($urandom_range(0, 255)));
            end
            else send_key(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
